// ===== design/ir_pulse_distance_learner_defines.svh =====
// assertion macros for the ir pulse distance learner
`ifndef IR_PULSE_DISTANCE_LEARNER_DEFINES_SVH
`define IR_PULSE_DISTANCE_LEARNER_DEFINES_SVH

// clocked check that is off while reset is high
`define IPDL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also holds during reset
`define IPDL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/ipdl_pkg.sv =====
// shared types, codes, constants and helpers for the ir pulse distance learner
package ipdl_pkg;

   localparam int IPDL_PATTERN_BYTES = 16;
   localparam int IPDL_COARSE_DIVIDE = 8;

   localparam logic [7:0] LEADER_MIN_RESET    = 8'd40;
   localparam logic [7:0] ONE_THRESHOLD_RESET = 8'd100;
   localparam logic [7:0] SPACE_TIMEOUT_RESET = 8'd240;
   localparam logic [7:0] COUNT_MAX           = 8'hFF;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_START = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NOP   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CSR_LEADER_MIN     = 2'd0,
      CSR_ONE_THRESHOLD  = 2'd1,
      CSR_SPACE_TIMEOUT  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0] action;
      logic       ir_level;
      logic [3:0] read_index;
   } req_payload_type;

   typedef struct packed {
      logic       busy_res;
      logic       done_res;
      logic [4:0] byte_count;
      logic [7:0] leader_mark;
      logic [7:0] leader_space;
      logic [7:0] mark_mid;
      logic [7:0] one_space_mid;
      logic [7:0] zero_space_mid;
      logic [7:0] read_data;
   } rsp_payload_type;

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      return (v == COUNT_MAX) ? v : v + 8'd1;
   endfunction

   function automatic logic [7:0] half_sum(input logic [7:0] mx, input logic [7:0] mn);
      return {1'b0, mx[7:1]} + {1'b0, mn[7:1]};
   endfunction

endpackage

// ===== design/ipdl_req_if.sv =====
// request channel: command and sample beats into the learner
interface ipdl_req_if import ipdl_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/ipdl_rsp_if.sv =====
// response channel: status and read beats out of the learner
interface ipdl_rsp_if import ipdl_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/ir_pulse_distance_learner.sv =====
// ir pulse distance learner: leader and bit timing capture with a pattern byte store
//
// req_bus carries one beat per sample tick, start command or byte read; every
// request beat yields exactly one rsp_bus beat with the status and timing after
// that beat, plus the stored byte for a read (zero otherwise).
// the response register and the registered store read are loaded on the edge that
// takes the request. one request beat per cycle is taken as long as the response
// register is empty or drained in the same cycle, so the sustained rate is one
// beat per clock.
// the pattern store is a PATTERN_BYTES x 8 synchronous memory, written when a byte
// completes and read by read beats; it is not cleared. the user must read a byte
// only after it has been captured; the block itself does not enforce this.
// csr_wr_en writes register csr_index (0 leader minimum, 1 one-space threshold,
// 2 space timeout) on any edge; write only while no beat is in flight.
// synchronous reset returns to idle with counters cleared, trackers at their
// empty values and the register defaults; the store keeps its contents.
// when rsp_bus.ready is low the response holds and req_bus.ready drops until the
// waiting beat is taken.
`include "ir_pulse_distance_learner_defines.svh"

module ir_pulse_distance_learner import ipdl_pkg::*; #(
   parameter int PATTERN_BYTES = IPDL_PATTERN_BYTES,
   parameter int COARSE_DIVIDE = IPDL_COARSE_DIVIDE
) (
   input  logic         clock,
   input  logic         reset,
   ipdl_req_if.sink     req_bus,
   ipdl_rsp_if.source   rsp_bus,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_index,
   input  logic [7:0]   csr_wdata
);

   localparam int ADDR_W = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;
   localparam int BPOS_W = $clog2(PATTERN_BYTES + 1);
   localparam int PS_W   = (COARSE_DIVIDE > 1) ? $clog2(COARSE_DIVIDE) : 1;
   localparam logic [PS_W:0]       DIV_VAL = (PS_W + 1)'(COARSE_DIVIDE);
   localparam logic [BPOS_W-1:0]   PB_VAL  = BPOS_W'(PATTERN_BYTES);
   localparam logic [ADDR_W+4:0]   PB_WIDE = (ADDR_W + 5)'(PATTERN_BYTES);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAIT,
      PH_LMARK,
      PH_LSPACE,
      PH_BMARK,
      PH_BSPACE,
      PH_DONE
   } phase_type;

   function automatic logic [PS_W+7:0] coarse_step(input logic [PS_W-1:0] ps,
                                                   input logic [7:0] tc);
      logic [PS_W:0] nxt;
      nxt = {1'b0, ps} + 1'b1;
      if (nxt >= DIV_VAL) return {{PS_W{1'b0}}, sat_inc(tc)};
      else return {nxt[PS_W-1:0], tc};
   endfunction

   // state registers
   phase_type         phase_ff, phase_in;
   logic [7:0]        tc_ff, tc_in;
   logic [PS_W-1:0]   ps_ff, ps_in;
   logic [7:0]        leader_mark_ff, leader_mark_in;
   logic [7:0]        leader_space_ff, leader_space_in;
   logic [BPOS_W-1:0] byte_pos_ff, byte_pos_in;
   logic [2:0]        bit_pos_ff, bit_pos_in;
   logic [7:0]        shift_byte_ff, shift_byte_in;
   logic [7:0]        mark_max_ff, mark_max_in, mark_min_ff, mark_min_in;
   logic [7:0]        one_max_ff, one_max_in, one_min_ff, one_min_in;
   logic [7:0]        zero_max_ff, zero_max_in, zero_min_ff, zero_min_in;
   logic [7:0]        leader_min_ff, leader_min_in;
   logic [7:0]        one_thr_ff, one_thr_in;
   logic [7:0]        timeout_ff, timeout_in;

   // response stage
   logic              rsp_valid_ff;
   rsp_payload_type   rsp_data_ff, rsp_in;
   logic              rd_sel_ff, rd_sel_in;
   logic [7:0]        rd_data_ff;

   // pattern store
   logic [7:0]        store_mem [PATTERN_BYTES];
   logic              mem_we, mem_re;
   logic [7:0]        mem_wdata;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [ADDR_W+BPOS_W-1:0] wa_wide;
   logic [ADDR_W+4:0] ri_wide;
   logic [BPOS_W+4:0] bc_wide;

   logic              req_fire;
   logic              level;
   logic              one_bit;
   logic [7:0]        tc_sat;
   logic [7:0]        shift_next;
   logic [BPOS_W-1:0] bpos_inc;
   logic [PS_W+7:0]   coarse_cont, coarse_new;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign level         = req_bus.payload.ir_level;

   assign wa_wide = {{ADDR_W{1'b0}}, byte_pos_ff};
   assign wr_addr = wa_wide[ADDR_W-1:0];
   assign ri_wide = {{(ADDR_W + 1){1'b0}}, req_bus.payload.read_index};
   assign rd_addr = ri_wide[ADDR_W-1:0];

   always_comb begin
      phase_in        = phase_ff;
      tc_in           = tc_ff;
      ps_in           = ps_ff;
      leader_mark_in  = leader_mark_ff;
      leader_space_in = leader_space_ff;
      byte_pos_in     = byte_pos_ff;
      bit_pos_in      = bit_pos_ff;
      shift_byte_in   = shift_byte_ff;
      mark_max_in     = mark_max_ff;
      mark_min_in     = mark_min_ff;
      one_max_in      = one_max_ff;
      one_min_in      = one_min_ff;
      zero_max_in     = zero_max_ff;
      zero_min_in     = zero_min_ff;
      leader_min_in   = leader_min_ff;
      one_thr_in      = one_thr_ff;
      timeout_in      = timeout_ff;
      mem_we          = 1'b0;
      mem_re          = 1'b0;
      rd_sel_in       = 1'b0;

      one_bit     = tc_ff > one_thr_ff;
      tc_sat      = sat_inc(tc_ff);
      shift_next  = {shift_byte_ff[6:0], one_bit};
      mem_wdata   = shift_next;
      bpos_inc    = byte_pos_ff + 1'b1;
      coarse_cont = coarse_step(ps_ff, tc_ff);
      coarse_new  = coarse_step('0, 8'd0);

      if (csr_wr_en) begin
         case (csr_index)
            CSR_LEADER_MIN:    leader_min_in = csr_wdata;
            CSR_ONE_THRESHOLD: one_thr_in    = csr_wdata;
            CSR_SPACE_TIMEOUT: timeout_in    = csr_wdata;
            default: ;
         endcase
      end

      if (req_fire) begin
         unique case (req_bus.payload.action)
            ACT_TICK: begin
               unique case (phase_ff)
                  PH_WAIT: begin
                     if (level) begin
                        tc_in = 8'd0;
                        ps_in = '0;
                     end else begin
                        {ps_in, tc_in} = coarse_cont;
                        if (coarse_cont[7:0] >= leader_min_ff) phase_in = PH_LMARK;
                     end
                  end
                  PH_LMARK: begin
                     if (!level) begin
                        {ps_in, tc_in} = coarse_cont;
                     end else begin
                        leader_mark_in = tc_ff;
                        {ps_in, tc_in} = coarse_new;
                        phase_in       = PH_LSPACE;
                     end
                  end
                  PH_LSPACE: begin
                     if (level) begin
                        {ps_in, tc_in} = coarse_cont;
                     end else begin
                        leader_space_in = tc_ff;
                        tc_in           = 8'd1;
                        ps_in           = '0;
                        phase_in        = PH_BMARK;
                     end
                  end
                  PH_BMARK: begin
                     if (!level) begin
                        tc_in = tc_sat;
                     end else begin
                        // min and max updated independently
                        if (tc_ff > mark_max_ff) mark_max_in = tc_ff;
                        if (tc_ff < mark_min_ff) mark_min_in = tc_ff;
                        tc_in    = 8'd1;
                        ps_in    = '0;
                        phase_in = (8'd1 >= timeout_ff) ? PH_DONE : PH_BSPACE;
                     end
                  end
                  PH_BSPACE: begin
                     if (level) begin
                        tc_in = tc_sat;
                        if (tc_sat >= timeout_ff) phase_in = PH_DONE;
                     end else if (tc_ff >= timeout_ff) begin
                        phase_in = PH_DONE;
                     end else begin
                        shift_byte_in = shift_next;
                        if (one_bit) begin
                           if (tc_ff > one_max_ff) one_max_in = tc_ff;
                           if (tc_ff < one_min_ff) one_min_in = tc_ff;
                        end else begin
                           if (tc_ff > zero_max_ff) zero_max_in = tc_ff;
                           if (tc_ff < zero_min_ff) zero_min_in = tc_ff;
                        end
                        bit_pos_in = bit_pos_ff + 3'd1;
                        tc_in      = 8'd1;
                        ps_in      = '0;
                        phase_in   = PH_BMARK;
                        if (bit_pos_ff == 3'd7) begin
                           // byte complete: write it back to the store
                           mem_we        = byte_pos_ff < PB_VAL;
                           byte_pos_in   = bpos_inc;
                           bit_pos_in    = 3'd0;
                           shift_byte_in = 8'd0;
                           if (bpos_inc >= PB_VAL) phase_in = PH_DONE;
                        end
                     end
                  end
                  PH_IDLE, PH_DONE: ;
                  default: ;
               endcase
            end
            ACT_START: begin
               phase_in        = PH_WAIT;
               tc_in           = 8'd0;
               ps_in           = '0;
               leader_mark_in  = 8'd0;
               leader_space_in = 8'd0;
               byte_pos_in     = '0;
               bit_pos_in      = 3'd0;
               shift_byte_in   = 8'd0;
               mark_max_in     = 8'd0;
               mark_min_in     = COUNT_MAX;
               one_max_in      = 8'd0;
               one_min_in      = COUNT_MAX;
               zero_max_in     = 8'd0;
               zero_min_in     = COUNT_MAX;
            end
            ACT_READ: begin
               mem_re    = 1'b1;
               rd_sel_in = ri_wide < PB_WIDE;
            end
            ACT_NOP: ;
         endcase
      end

      bc_wide               = {5'd0, byte_pos_in};
      rsp_in.busy_res       = (phase_in != PH_IDLE) && (phase_in != PH_DONE);
      rsp_in.done_res       = phase_in == PH_DONE;
      rsp_in.byte_count     = bc_wide[4:0];
      rsp_in.leader_mark    = leader_mark_in;
      rsp_in.leader_space   = leader_space_in;
      rsp_in.mark_mid       = half_sum(mark_max_in, mark_min_in);
      rsp_in.one_space_mid  = half_sum(one_max_in, one_min_in);
      rsp_in.zero_space_mid = half_sum(zero_max_in, zero_min_in);
      rsp_in.read_data      = 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         tc_ff           <= 8'd0;
         ps_ff           <= '0;
         leader_mark_ff  <= 8'd0;
         leader_space_ff <= 8'd0;
         byte_pos_ff     <= '0;
         bit_pos_ff      <= 3'd0;
         shift_byte_ff   <= 8'd0;
         mark_max_ff     <= 8'd0;
         mark_min_ff     <= COUNT_MAX;
         one_max_ff      <= 8'd0;
         one_min_ff      <= COUNT_MAX;
         zero_max_ff     <= 8'd0;
         zero_min_ff     <= COUNT_MAX;
         leader_min_ff   <= LEADER_MIN_RESET;
         one_thr_ff      <= ONE_THRESHOLD_RESET;
         timeout_ff      <= SPACE_TIMEOUT_RESET;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         tc_ff           <= tc_in;
         ps_ff           <= ps_in;
         leader_mark_ff  <= leader_mark_in;
         leader_space_ff <= leader_space_in;
         byte_pos_ff     <= byte_pos_in;
         bit_pos_ff      <= bit_pos_in;
         shift_byte_ff   <= shift_byte_in;
         mark_max_ff     <= mark_max_in;
         mark_min_ff     <= mark_min_in;
         one_max_ff      <= one_max_in;
         one_min_ff      <= one_min_in;
         zero_max_ff     <= zero_max_in;
         zero_min_ff     <= zero_min_in;
         leader_min_ff   <= leader_min_in;
         one_thr_ff      <= one_thr_in;
         timeout_ff      <= timeout_in;
         rsp_valid_ff    <= req_fire || (rsp_valid_ff && !rsp_bus.ready);
      end
      if (req_fire) begin
         rsp_data_ff <= rsp_in;
         rd_sel_ff   <= rd_sel_in;
      end
   end

   // write and read never come from the same beat, and a write lands before
   // the next beat can read, so no forwarding path is needed
   always_ff @(posedge clock) begin
      if (mem_we) store_mem[wr_addr] <= mem_wdata;
      if (mem_re) rd_data_ff <= store_mem[rd_addr];
   end

   assign rsp_bus.valid = rsp_valid_ff;

   always_comb begin
      rsp_bus.payload           = rsp_data_ff;
      rsp_bus.payload.read_data = rd_sel_ff ? rd_data_ff : 8'd0;
   end

   `IPDL_ASSERT(a_write_in_bit_space, mem_we |-> (phase_ff == PH_BSPACE && req_fire), "store write outside a bit space")
   `IPDL_ASSERT(a_fire_gives_beat, req_fire |=> rsp_valid_ff, "accepted beat left no response")
   `IPDL_ASSERT(a_start_rearms, (req_fire && req_bus.payload.action == ACT_START) |=> (phase_ff == PH_WAIT && byte_pos_ff == '0), "start did not rearm the capture")
   `IPDL_ASSERT(a_byte_pos_bound, byte_pos_ff <= PB_VAL, "byte position past the store")

endmodule

// ===== tb/ir_pulse_distance_learner_tb.sv =====
// self-checking testbench for the ir pulse distance learner: frames of ticks in, status checked
`timescale 1ns / 100ps

module ir_pulse_distance_learner_tb;
   import ipdl_pkg::*;

   typedef enum logic [2:0] {
      LP_IDLE,
      LP_ARMED,
      LP_LEAD_MARK,
      LP_LEAD_SPACE,
      LP_BIT_MARK,
      LP_BIT_SPACE,
      LP_DONE
   } learn_phase_type;

   localparam logic LVL_MARK  = 1'b0;
   localparam logic LVL_SPACE = 1'b1;
   localparam int ITEM_BUDGET = 1450;
   localparam int LONG_HOLD   = 80;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [1:0] csr_index = 2'b00;
   logic [7:0] csr_wdata = 8'h00;

   ipdl_req_if req_bus ();
   ipdl_rsp_if rsp_bus ();

   ir_pulse_distance_learner dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // capture predictor state
   logic [7:0]   cfg_leader_min, cfg_one_thresh, cfg_space_timeout;
   learn_phase_type lphase;
   logic [7:0]   tick_cnt;
   int           pre_cnt;
   logic [7:0]   lead_mark_len, lead_space_len;
   logic [7:0]   store_img [IPDL_PATTERN_BYTES];
   logic [IPDL_PATTERN_BYTES-1:0] store_written;
   int           byte_idx, bit_idx;
   logic [7:0]   shift_acc;
   logic [7:0]   mark_hi, mark_lo, one_hi, one_lo, zero_hi, zero_lo;

   req_payload_type pending_beats [$];
   rsp_payload_type expected_status [$];
   logic [IPDL_PATTERN_BYTES-1:0] readable_mask = '0;

   int  mismatch_count = 0;
   int  results_checked = 0;
   int  frames_built = 0;
   int  reg_writes = 0;
   int  beats_queued = 0;
   int  pressure_requests = 0;
   int  pressure_served;
   bit  idle_on = 1'b1;
   logic req_fire;
   int  send_gap, recv_gap, hold_left;

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void fine_count();
      if (tick_cnt != COUNT_MAX) tick_cnt = tick_cnt + 8'd1;
   endfunction

   function automatic void coarse_count();
      pre_cnt++;
      if (pre_cnt >= IPDL_COARSE_DIVIDE) begin
         pre_cnt = 0;
         fine_count();
      end
   endfunction

   function automatic void restart_count();
      tick_cnt = 8'd0;
      pre_cnt = 0;
   endfunction

   function automatic void widen(input logic [7:0] v, inout logic [7:0] hi,
                                 inout logic [7:0] lo);
      if (v > hi) hi = v;
      if (v < lo) lo = v;
   endfunction

   function automatic logic [7:0] midpoint(input logic [7:0] hi, input logic [7:0] lo);
      return (hi >> 1) + (lo >> 1);
   endfunction

   function automatic void clear_capture();
      restart_count();
      lead_mark_len = 8'd0;
      lead_space_len = 8'd0;
      byte_idx = 0;
      bit_idx = 0;
      shift_acc = 8'd0;
      mark_hi = 8'd0;
      mark_lo = COUNT_MAX;
      one_hi = 8'd0;
      one_lo = COUNT_MAX;
      zero_hi = 8'd0;
      zero_lo = COUNT_MAX;
   endfunction

   function automatic void learner_reset();
      cfg_leader_min = LEADER_MIN_RESET;
      cfg_one_thresh = ONE_THRESHOLD_RESET;
      cfg_space_timeout = SPACE_TIMEOUT_RESET;
      lphase = LP_IDLE;
      store_written = '0;
      for (int i = 0; i < IPDL_PATTERN_BYTES; i++) store_img[i] = 8'h00;
      clear_capture();
   endfunction

   function automatic void learner_tick(input logic level);
      logic bit_is_one;
      case (lphase)
         LP_ARMED: begin
            if (level == LVL_SPACE) begin
               restart_count();
            end else begin
               coarse_count();
               if (tick_cnt >= cfg_leader_min) lphase = LP_LEAD_MARK;
            end
         end
         LP_LEAD_MARK: begin
            if (level == LVL_MARK) begin
               coarse_count();
            end else begin
               lead_mark_len = tick_cnt;
               restart_count();
               coarse_count();
               lphase = LP_LEAD_SPACE;
            end
         end
         LP_LEAD_SPACE: begin
            if (level == LVL_SPACE) begin
               coarse_count();
            end else begin
               lead_space_len = tick_cnt;
               restart_count();
               fine_count();
               lphase = LP_BIT_MARK;
            end
         end
         LP_BIT_MARK: begin
            if (level == LVL_MARK) begin
               fine_count();
            end else begin
               widen(tick_cnt, mark_hi, mark_lo);
               restart_count();
               fine_count();
               lphase = (tick_cnt >= cfg_space_timeout) ? LP_DONE : LP_BIT_SPACE;
            end
         end
         LP_BIT_SPACE: begin
            if (level == LVL_SPACE) begin
               fine_count();
               if (tick_cnt >= cfg_space_timeout) lphase = LP_DONE;
            end else if (tick_cnt >= cfg_space_timeout) begin
               lphase = LP_DONE;
            end else begin
               // the mark that follows a space closes the bit
               bit_is_one = tick_cnt > cfg_one_thresh;
               shift_acc = {shift_acc[6:0], bit_is_one};
               if (bit_is_one) widen(tick_cnt, one_hi, one_lo);
               else widen(tick_cnt, zero_hi, zero_lo);
               bit_idx++;
               restart_count();
               fine_count();
               lphase = LP_BIT_MARK;
               if (bit_idx >= 8) begin
                  store_img[byte_idx] = shift_acc;
                  store_written[byte_idx] = 1'b1;
                  byte_idx++;
                  bit_idx = 0;
                  shift_acc = 8'd0;
                  if (byte_idx >= IPDL_PATTERN_BYTES) lphase = LP_DONE;
               end
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic rsp_payload_type learner_step(input req_payload_type rq);
      rsp_payload_type rs;
      logic [7:0] rd;
      rd = 8'h00;
      case (rq.action)
         ACT_TICK: learner_tick(rq.ir_level);
         ACT_START: begin
            clear_capture();
            lphase = LP_ARMED;
         end
         ACT_READ: rd = store_img[rq.read_index];
         default: begin
         end
      endcase
      rs.busy_res = (lphase != LP_IDLE) && (lphase != LP_DONE);
      rs.done_res = (lphase == LP_DONE);
      rs.byte_count = 5'(byte_idx);
      rs.leader_mark = lead_mark_len;
      rs.leader_space = lead_space_len;
      rs.mark_mid = midpoint(mark_hi, mark_lo);
      rs.one_space_mid = midpoint(one_hi, one_lo);
      rs.zero_space_mid = midpoint(zero_hi, zero_lo);
      rs.read_data = rd;
      return rs;
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatch_count++;
      $display("mismatch: %s at beat %0d got %0h expected %0h",
               what, results_checked, got, want);
   endtask

   task automatic check_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_status.size() == 0) begin
         report_mismatch("response beat with nothing pending", 8'h00, 8'h00);
         return;
      end
      want = expected_status.pop_front();
      results_checked++;
      if (got.busy_res !== want.busy_res)
         report_mismatch("busy_res", got.busy_res, want.busy_res);
      if (got.done_res !== want.done_res)
         report_mismatch("done_res", got.done_res, want.done_res);
      if (got.byte_count !== want.byte_count)
         report_mismatch("byte_count", got.byte_count, want.byte_count);
      if (got.leader_mark !== want.leader_mark)
         report_mismatch("leader_mark", got.leader_mark, want.leader_mark);
      if (got.leader_space !== want.leader_space)
         report_mismatch("leader_space", got.leader_space, want.leader_space);
      if (got.mark_mid !== want.mark_mid)
         report_mismatch("mark_mid", got.mark_mid, want.mark_mid);
      if (got.one_space_mid !== want.one_space_mid)
         report_mismatch("one_space_mid", got.one_space_mid, want.one_space_mid);
      if (got.zero_space_mid !== want.zero_space_mid)
         report_mismatch("zero_space_mid", got.zero_space_mid, want.zero_space_mid);
      if (got.read_data !== want.read_data)
         report_mismatch("read_data", got.read_data, want.read_data);
   endtask

   // monitor: compare the response beat first, then predict the request beat
   always @(posedge clock) begin
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) check_result(rsp_bus.payload);
         if (req_bus.valid && req_bus.ready)
            expected_status.push_back(learner_step(req_bus.payload));
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap <= 0;
      end else if (req_bus.valid && !req_fire) begin
         // beat still waiting, hold it
      end else if (send_gap > 0) begin
         req_bus.valid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         req_bus.valid <= 1'b0;
         send_gap <= $urandom_range(0, 4);
      end else if (pending_beats.size() != 0) begin
         req_bus.payload <= pending_beats.pop_front();
         req_bus.valid <= 1'b1;
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // response receiver with random stalls and the occasional long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_gap <= 0;
         hold_left <= 0;
         pressure_served <= 0;
      end else if (pressure_served != pressure_requests) begin
         pressure_served <= pressure_requests;
         hold_left <= LONG_HOLD - 1;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         recv_gap <= $urandom_range(0, 4);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic push_beat(input action_type act, input logic lvl, input logic [3:0] idx);
      req_payload_type b;
      b.action = act;
      b.ir_level = lvl;
      b.read_index = idx;
      pending_beats.push_back(b);
      beats_queued++;
   endtask

   // a read of a byte known to be captured, or a no-op
   task automatic push_aside();
      logic [3:0] idx;
      idx = 4'($urandom);
      if (readable_mask == '0 || $urandom_range(0, 3) == 0) begin
         push_beat(ACT_NOP, 1'($urandom), idx);
      end else begin
         while (!readable_mask[idx]) idx = 4'($urandom);
         push_beat(ACT_READ, 1'($urandom), idx);
      end
   endtask

   task automatic push_run(input logic lvl, input int n);
      for (int k = 0; k < n; k++) begin
         push_beat(ACT_TICK, lvl, 4'($urandom));
         if ($urandom_range(0, 15) == 0) push_aside();
      end
   endtask

   // ticks after the capture has finished
   task automatic push_filler(input int n);
      for (int k = 0; k < n; k++) push_beat(ACT_TICK, 1'($urandom), 4'($urandom));
   endtask

   task automatic gen_frame(input int nbits, input bit complete, input int mark_top,
                            input int span);
      int  lm, thr, tout, nb, hi, lo;
      bit  can_zero, can_one, one;
      lm = cfg_leader_min;
      thr = cfg_one_thresh;
      tout = cfg_space_timeout;
      can_zero = (thr >= 1) && (tout >= 2);
      can_one = (thr + 1 <= tout - 1);
      nb = (can_zero || can_one) ? ((nbits > 8 * IPDL_PATTERN_BYTES) ?
                                    8 * IPDL_PATTERN_BYTES : nbits) : 0;
      frames_built++;
      push_beat(ACT_START, 1'($urandom), 4'($urandom));
      if ($urandom_range(0, 2) == 0) begin
         // a mark too short to pass as a leader
         push_run(LVL_MARK, $urandom_range(1, (lm * 8 - 1 < 30) ? lm * 8 - 1 : 30));
         push_run(LVL_SPACE, $urandom_range(1, 5));
      end
      push_run(LVL_MARK, lm * 8 + $urandom_range(0, 24));
      push_run(LVL_SPACE, $urandom_range(1, 48));
      for (int b = 0; b < nb; b++) begin
         push_run(LVL_MARK, $urandom_range(1, mark_top));
         one = can_one && (!can_zero || $urandom_range(0, 1) == 1);
         if (one) begin
            lo = thr + 1;
            hi = (thr + span < tout - 1) ? thr + span : tout - 1;
         end else begin
            hi = (thr < tout - 1) ? thr : tout - 1;
            lo = (hi - span + 1 > 1) ? hi - span + 1 : 1;
         end
         push_run(LVL_SPACE, $urandom_range(lo, hi));
      end
      // trailing mark closes the last bit
      push_run(LVL_MARK, $urandom_range(1, mark_top));
      if (complete && nb < 8 * IPDL_PATTERN_BYTES) push_run(LVL_SPACE, tout);
      if (complete) push_filler($urandom_range(0, 6));
   endtask

   task automatic wait_drained();
      while (pending_beats.size() != 0 || req_bus.valid || expected_status.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
      readable_mask = store_written;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [7:0] val);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_LEADER_MIN:    cfg_leader_min = val;
         CSR_ONE_THRESHOLD: cfg_one_thresh = val;
         CSR_SPACE_TIMEOUT: cfg_space_timeout = val;
         default: begin
         end
      endcase
      reg_writes++;
   endtask

   task automatic set_config(input int lmin, input int thr, input int tout);
      wait_drained();
      write_reg(CSR_LEADER_MIN, 8'(lmin));
      write_reg(CSR_ONE_THRESHOLD, 8'(thr));
      write_reg(CSR_SPACE_TIMEOUT, 8'(tout));
   endtask

   initial begin
      int lmin, thr, tout, nframes, phase_no;
      req_bus.valid = 1'b0;
      req_bus.payload = '0;
      rsp_bus.ready = 1'b0;
      learner_reset();
      repeat (12) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // idle ticks are ignored, then a start under the default registers
      push_beat(ACT_TICK, LVL_MARK, 4'hF);
      push_beat(ACT_TICK, LVL_SPACE, 4'h0);
      push_beat(ACT_NOP, 1'b1, 4'hA);
      push_beat(ACT_START, 1'b0, 4'h5);
      push_run(LVL_MARK, 20);
      push_run(LVL_SPACE, 2);

      // short bits until the store is full, with the receiver held off meanwhile
      set_config(1, 1, 3);
      gen_frame(8 * IPDL_PATTERN_BYTES, 1'b1, 1, 1);
      push_filler(4);
      pressure_requests++;

      // read back every byte, then restart mid-capture and lose a partial byte
      wait_drained();
      for (int i = 0; i < IPDL_PATTERN_BYTES; i++) push_beat(ACT_READ, 1'($urandom), 4'(i));
      push_beat(ACT_NOP, 1'b0, 4'h3);
      push_beat(ACT_START, 1'b1, 4'h0);
      push_run(LVL_MARK, 12);
      push_run(LVL_SPACE, 5);
      push_run(LVL_MARK, 1);
      push_run(LVL_SPACE, 2);
      push_run(LVL_MARK, 1);
      gen_frame(3, 1'b1, 3, 4);

      // zero threshold with the shortest timeout ends on the first space tick
      set_config(1, 0, 1);
      gen_frame(4, 1'b1, 2, 2);

      // overlong bit mark saturates the fine count, then both bit kinds and a timeout
      set_config(2, 20, 30);
      push_beat(ACT_START, 1'b0, 4'h9);
      push_run(LVL_MARK, 20);
      push_run(LVL_SPACE, 3);
      push_run(LVL_MARK, 260);
      push_run(LVL_SPACE, 25);
      push_run(LVL_MARK, 3);
      push_run(LVL_SPACE, 10);
      push_run(LVL_MARK, 2);
      push_run(LVL_SPACE, 30);
      push_filler(3);
      frames_built++;

      phase_no = 0;
      while (beats_queued < ITEM_BUDGET) begin
         case ($urandom_range(0, 5))
            0: begin
               lmin = 1;
               thr = 0;
               tout = 255;
            end
            1: begin
               lmin = $urandom_range(1, 2);
               thr = $urandom_range(1, 8);
               tout = thr + 2;
            end
            default: begin
               lmin = $urandom_range(1, 3);
               thr = $urandom_range(0, 10);
               tout = thr + $urandom_range(2, 16);
            end
         endcase
         set_config(lmin, thr, tout);
         if (beats_queued > ITEM_BUDGET * 3 / 4) idle_on = 1'b0;
         nframes = $urandom_range(1, 3);
         for (int f = 0; f < nframes && beats_queued < ITEM_BUDGET; f++) begin
            gen_frame($urandom_range(0, 20),
                      (f == nframes - 1) || ($urandom_range(0, 3) != 0),
                      $urandom_range(1, 6), $urandom_range(1, 8));
         end
         // in the first round only, hold the receiver off while the queue is full of beats
         if (idle_on && phase_no == 0) pressure_requests++;
         phase_no++;
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("run covered %0d capture frames, %0d register writes, %0d response beats",
               frames_built, reg_writes, results_checked);
      if (mismatch_count == 0 && expected_status.size() == 0) begin
         $display("ir_pulse_distance_learner verification clean");
      end else begin
         $display("ir_pulse_distance_learner verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("ir_pulse_distance_learner verification failed");
      $finish;
   end

endmodule
